/* design/yuv_to_rgb565_pixel_pair_unit_assert.svh */
// Assertion macros shared by the checkers of the pixel pair converter.
// Each macro samples on the rising clock edge and is disabled while reset is low.
`ifndef YUV_TO_RGB565_PIXEL_PAIR_UNIT_ASSERT_SVH
`define YUV_TO_RGB565_PIXEL_PAIR_UNIT_ASSERT_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in the pixel pair converter");

// When the antecedent holds, the consequent must hold in the following cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in the pixel pair converter");

`endif

/* design/yuvpp_pkg.sv */
package yuvpp_pkg;

    // Width of every signed channel sum; the largest magnitude stays below 2^23.
    localparam int SUM_W = 24;
    // Bit position where the channel value starts in a clamped sum.
    localparam int CH_LSB = 16;

    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [7:0]              sample_t;
    typedef logic [15:0]             rgb565_t;
    typedef logic signed [8:0]       chroma_t;

    // Fixed-point BT.601 full-range coefficients.
    localparam sum_t FAC_RY     = sum_t'(31 * 257);
    localparam sum_t FAC_GY     = sum_t'(63 * 257);
    localparam sum_t FAC_BY     = sum_t'(31 * 257);
    localparam sum_t FAC_RV     = sum_t'(11170);
    localparam sum_t FAC_GV     = sum_t'(-11563);
    localparam sum_t FAC_GU     = sum_t'(-5572);
    localparam sum_t FAC_BU     = sum_t'(14118);
    localparam sum_t RND_OFFSET = sum_t'(127 * 257);
    localparam chroma_t CHROMA_ZERO = chroma_t'(128);

    // Upper clamp limits of the channel sums.
    localparam sum_t TOP_R = sum_t'(31 * 257 * 255 + 127 * 257);
    localparam sum_t TOP_G = sum_t'(63 * 257 * 255 + 127 * 257);
    localparam sum_t TOP_B = sum_t'(31 * 257 * 255 + 127 * 257);

    // Chroma contributions shared by both pixels of a pair, rounding offset included.
    typedef struct packed {
        sum_t red;
        sum_t green;
        sum_t blue;
    } chroma_terms_t;

    // Clamps a channel sum to [0, top] and returns its top bits.
    function automatic logic [5:0] clamp_channel(sum_t sum, sum_t top);
        sum_t clamped;
        if (sum < 0)
        begin
            clamped = '0;
        end
        else if (sum > top)
        begin
            clamped = top;
        end
        else
        begin
            clamped = sum;
        end
        return clamped[CH_LSB+5:CH_LSB];
    endfunction

endpackage

/* design/yuvpp_chroma.sv */
module yuvpp_chroma (
    input  logic                     clk,
    input  logic                     load,
    input  yuvpp_pkg::sample_t       chroma_blue,
    input  yuvpp_pkg::sample_t       chroma_red,
    output yuvpp_pkg::chroma_terms_t terms
);
    import yuvpp_pkg::*;

    chroma_t       u;
    chroma_t       v;
    sum_t          u_ext;
    sum_t          v_ext;
    chroma_terms_t terms_next;
    chroma_terms_t terms_reg;

    // Remove the chroma bias and sign-extend to the sum width.
    assign u     = $signed({1'b0, chroma_blue}) - CHROMA_ZERO;
    assign v     = $signed({1'b0, chroma_red}) - CHROMA_ZERO;
    assign u_ext = sum_t'(u);
    assign v_ext = sum_t'(v);

    // Constant chroma products for each channel term, the rounding offset folded in.
    always_comb
    begin
        terms_next.red   = FAC_RV * v_ext + RND_OFFSET;
        terms_next.green = FAC_GV * v_ext + FAC_GU * u_ext + RND_OFFSET;
        terms_next.blue  = FAC_BU * u_ext + RND_OFFSET;
    end

    // Pipeline register of the shared chroma terms.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            terms_reg <= terms_next;
        end
    end

    assign terms = terms_reg;

endmodule

/* design/yuvpp_lane.sv */
module yuvpp_lane (
    input  yuvpp_pkg::sample_t       luma,
    input  yuvpp_pkg::chroma_terms_t terms,
    output yuvpp_pkg::rgb565_t       pixel
);
    import yuvpp_pkg::*;

    sum_t       luma_ext;
    sum_t       sum_r;
    sum_t       sum_g;
    sum_t       sum_b;
    logic [5:0] chan_r;
    logic [5:0] chan_g;
    logic [5:0] chan_b;

    // Luma is unsigned, so it is zero-extended.
    assign luma_ext = sum_t'({1'b0, luma});

    // Channel sums of this pixel.
    assign sum_r = FAC_RY * luma_ext + terms.red;
    assign sum_g = FAC_GY * luma_ext + terms.green;
    assign sum_b = FAC_BY * luma_ext + terms.blue;

    // Clamp each sum and take its top bits.
    assign chan_r = clamp_channel(sum_r, TOP_R);
    assign chan_g = clamp_channel(sum_g, TOP_G);
    assign chan_b = clamp_channel(sum_b, TOP_B);

    assign pixel = {chan_r[4:0], chan_g, chan_b[4:0]};

endmodule

/* design/yuv_to_rgb565_pixel_pair_unit.sv */
// Pixel pair converter from YUV to RGB565, BT.601 full range.
//
// Input channel (s_tvalid, s_tready, s_tdata): one item carries two adjacent
// luma samples and the chroma pair they share, chroma biased by 128.
// Output channel (m_tvalid, m_tready, m_tdata): one item per input item with
// both pixels packed as RGB565, red in the top five bits.
//
// Throughput is one item per cycle while m_tready is high; the first stage
// forms the chroma products, the second runs two identical pixel lanes in
// parallel and loads the output register.
// An item is accepted while the output register is still waiting to be taken
// as long as the first stage can move forward, so the pipeline stays full.
//
// When the receiver holds m_tready low, the output item holds and the first
// stage fills; s_tready then drops until the output is taken.
// Reset empties both stages; no item is lost across a stall.
module yuv_to_rgb565_pixel_pair_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // luma_first [7:0], luma_second [15:8], chroma_blue [23:16], chroma_red [31:24]
    input  logic [31:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // pixel_first [15:0], pixel_second [31:16]
    output logic [31:0] m_tdata
);
    import yuvpp_pkg::*;

    logic          stage1_load;
    logic          out_load;
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    sample_t       luma_first_reg;
    sample_t       luma_second_reg;
    chroma_terms_t terms;
    rgb565_t       lane_first;
    rgb565_t       lane_second;
    rgb565_t       pixel_first_reg;
    rgb565_t       pixel_second_reg;

    // Stage enables: each stage loads when it is empty or the one after it takes its item.
    assign out_load    = !out_valid_reg || m_tready;
    assign stage1_load = !s1_valid_reg || out_load;
    assign s_tready    = stage1_load;

    assign s1_valid_next  = stage1_load ? s_tvalid : s1_valid_reg;
    assign out_valid_next = out_load ? s1_valid_reg : out_valid_reg;

    // Valid flags of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // First stage: luma samples wait beside the chroma products.
    always_ff @(posedge clk)
    begin
        if (stage1_load)
        begin
            luma_first_reg  <= s_tdata[7:0];
            luma_second_reg <= s_tdata[15:8];
        end
    end

    yuvpp_chroma u_chroma (
        .clk         (clk),
        .load        (stage1_load),
        .chroma_blue (s_tdata[23:16]),
        .chroma_red  (s_tdata[31:24]),
        .terms       (terms)
    );

    // Two pixel lanes share the chroma terms.
    yuvpp_lane u_lane_first (
        .luma  (luma_first_reg),
        .terms (terms),
        .pixel (lane_first)
    );

    yuvpp_lane u_lane_second (
        .luma  (luma_second_reg),
        .terms (terms),
        .pixel (lane_second)
    );

    // Output register merges both lanes into one item.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pixel_first_reg  <= lane_first;
            pixel_second_reg <= lane_second;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {pixel_second_reg, pixel_first_reg};

endmodule

/* design/yuvpp_checker.sv */
`include "yuv_to_rgb565_pixel_pair_unit_assert.svh"

module yuvpp_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    logic black_accept;

    // An accepted item with zero luma and neutral chroma.
    assign black_accept = s_tvalid && s_tready && (s_tdata == 32'h8080_0000);

    // A stalled output item keeps its data.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // The input side is open whenever the output register is empty or draining.
    `ASSERT_SAME(a_ready_flow, clk, rst_n, !m_tvalid || m_tready, s_tready)

    // An accepted item reaches the output register when the sink takes data while the item is in the first stage.
    `ASSERT_NEXT(a_latency, clk, rst_n, (s_tvalid && s_tready) ##1 m_tready, m_tvalid)

    // Black with neutral chroma converts to zero pixels.
    `ASSERT_NEXT(a_black, clk, rst_n, black_accept ##1 m_tready, m_tdata == 32'h0000_0000)

endmodule

bind yuv_to_rgb565_pixel_pair_unit yuvpp_checker u_checker (.*);
